>>> src/lrl_pkg.sv
// Package for the LRU recency list: field widths, default pool size,
// opcode and controller state types. No dependencies.
package lrl_pkg;

   localparam int ENTRIES_DEF = 256;
   localparam int ENTRY_W     = 8;
   localparam int OPCODE_W    = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_TOUCH  = 2'd1,
      OP_REMOVE = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_WR1,
      ST_WR2
   } state_type;

endpackage

>>> src/lrl_ram.sv
// Generic single-clock RAM: one write port with per-bit mask, one read
// port with registered read data. No dependencies.
module lrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_mask,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int b = 0; b < WIDTH; b++) begin
         if (wr_en && wr_mask[b]) begin
            mem_ff[wr_addr][b] <= wr_data[b];
         end
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lrl_ctrl.sv
// Sequencer for the LRU recency list: list ends, link update planning and
// RAM write sequencing. Uses lrl_pkg; drives two lrl_ram instances.
module lrl_ctrl
   import lrl_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF,
   localparam int IW     = $clog2(ENTRIES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [ENTRY_W-1:0]  req_entry,
   output logic                rsp_valid,
   output logic [ENTRY_W-1:0]  rsp_oldest_entry,
   output logic [ENTRY_W-1:0]  rsp_newest_entry,
   output logic                rsp_list_empty,
   output logic                rsp_misuse,
   // newer-link RAM
   output logic                nw_wr_en,
   output logic [IW-1:0]       nw_wr_addr,
   output logic [IW-1:0]       nw_wr_data,
   output logic [IW-1:0]       nw_rd_addr,
   input  logic [IW-1:0]       nw_rd_data,
   // {present, older-link} RAM
   output logic                ow_wr_en,
   output logic [IW-1:0]       ow_wr_addr,
   output logic [IW:0]         ow_wr_mask,
   output logic [IW:0]         ow_wr_data,
   output logic [IW-1:0]       ow_rd_addr,
   input  logic [IW:0]         ow_rd_data
);

   localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);
   localparam logic [IW:0]   PRES_MASK = {1'b1, {IW{1'b0}}};
   localparam logic [IW:0]   LINK_MASK = {1'b0, {IW{1'b1}}};

   state_type state_ff, state_in;

   logic [IW-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                range_ff, range_in;
   logic [IW-1:0]       newest_ff, newest_in;
   logic [IW-1:0]       oldest_ff, oldest_in;
   logic                empty_ff, empty_in;

   logic [1:0]    pend_nw_en_ff, pend_nw_en_in;
   logic [IW-1:0] pend_nw_addr_ff [2];
   logic [IW-1:0] pend_nw_addr_in [2];
   logic [IW-1:0] pend_nw_data_ff [2];
   logic [IW-1:0] pend_nw_data_in [2];
   logic          pend_ow_en_ff, pend_ow_en_in;
   logic [IW-1:0] pend_ow_addr_ff, pend_ow_addr_in;
   logic [IW:0]   pend_ow_mask_ff, pend_ow_mask_in;
   logic [IW:0]   pend_ow_data_ff, pend_ow_data_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0] rsp_oldest_ff, rsp_oldest_in;
   logic [ENTRY_W-1:0] rsp_newest_ff, rsp_newest_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_misuse_ff, rsp_misuse_in;

   logic          accept;
   logic          pres;
   logic [IW-1:0] ol, nw;
   logic          is_ins, is_tch, is_rem;
   logic          ins_ok, tch_ok, rem_ok, ok;
   logic          tch_mv, push, e_new, e_old, single;
   logic          do_a, do_b, ep_en;

   logic [2:0]    plan_nw_en;
   logic [IW-1:0] plan_nw_addr [3];
   logic [IW-1:0] plan_nw_data [3];
   logic [1:0]    plan_ow_en;
   logic [IW-1:0] plan_ow_addr [2];
   logic [IW:0]   plan_ow_mask [2];
   logic [IW:0]   plan_ow_data [2];
   logic [IW:0]   ep_mask, ep_data;

   assign accept = (state_ff == ST_IDLE) && start;

   // reads are harmless: the word captured at the accept edge is used
   assign nw_rd_addr = IW'(req_entry);
   assign ow_rd_addr = IW'(req_entry);

   // decode of the looked-up entry
   assign pres = ow_rd_data[IW];
   assign ol   = ow_rd_data[IW-1:0];
   assign nw   = nw_rd_data;

   always_comb begin
      is_ins = 1'b0;
      is_tch = 1'b0;
      is_rem = 1'b0;
      unique case (op_ff)
         OP_INSERT: is_ins = 1'b1;
         OP_TOUCH:  is_tch = 1'b1;
         OP_REMOVE: is_rem = 1'b1;
         default:   ;
      endcase
   end

   assign ins_ok = range_ff && is_ins && !pres;
   assign tch_ok = range_ff && is_tch && pres;
   assign rem_ok = range_ff && is_rem && pres;
   assign ok     = ins_ok || tch_ok || rem_ok;
   assign e_new  = (idx_ff == newest_ff);
   assign e_old  = (idx_ff == oldest_ff);
   assign single = (newest_ff == oldest_ff);
   assign tch_mv = tch_ok && !e_new;
   assign push   = ins_ok || tch_mv;
   // middle unlink: splice neighbours together
   assign do_a   = (tch_mv || (rem_ok && !single)) && !e_new && !e_old;
   // old newest gains a newer link, unless the list was empty
   assign do_b   = push && !(ins_ok && empty_ff);
   assign ep_en  = push || rem_ok;
   assign ep_mask = {ins_ok || rem_ok, {IW{push}}};
   assign ep_data = {ins_ok, newest_ff};

   // pack the writes of each RAM into consecutive slots
   always_comb begin
      plan_nw_en = '0;
      for (int k = 0; k < 3; k++) begin
         plan_nw_addr[k] = idx_ff;
         plan_nw_data[k] = idx_ff;
      end
      if (do_a) begin
         plan_nw_en      = {push, do_b, 1'b1};
         plan_nw_addr[0] = ol;
         plan_nw_data[0] = nw;
         plan_nw_addr[1] = newest_ff;
      end else if (do_b) begin
         plan_nw_en      = {1'b0, push, 1'b1};
         plan_nw_addr[0] = newest_ff;
      end else begin
         plan_nw_en      = {1'b0, 1'b0, push};
      end

      plan_ow_en      = '0;
      plan_ow_addr[0] = idx_ff;
      plan_ow_mask[0] = ep_mask;
      plan_ow_data[0] = ep_data;
      plan_ow_addr[1] = idx_ff;
      plan_ow_mask[1] = ep_mask;
      plan_ow_data[1] = ep_data;
      if (do_a) begin
         plan_ow_en      = {ep_en, 1'b1};
         plan_ow_addr[0] = nw;
         plan_ow_mask[0] = LINK_MASK;
         plan_ow_data[0] = {1'b0, ol};
      end else begin
         plan_ow_en      = {1'b0, ep_en};
      end
   end

   // list ends after the operation
   always_comb begin
      newest_in = newest_ff;
      oldest_in = oldest_ff;
      empty_in  = empty_ff;
      if (state_ff == ST_LOOK) begin
         priority if (ins_ok) begin
            newest_in = idx_ff;
            if (empty_ff) begin
               oldest_in = idx_ff;
               empty_in  = 1'b0;
            end
         end else if (tch_mv) begin
            newest_in = idx_ff;
            if (e_old) begin
               oldest_in = nw;
            end
         end else if (rem_ok) begin
            priority if (single) begin
               newest_in = '0;
               oldest_in = '0;
               empty_in  = 1'b1;
            end else if (e_new) begin
               newest_in = ol;
            end else if (e_old) begin
               oldest_in = nw;
            end else begin
               newest_in = newest_ff;
            end
         end else begin
            newest_in = newest_ff;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_cnt_ff == LAST_IDX) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_LOOK;
         ST_LOOK:  state_in = (plan_nw_en[1] || plan_ow_en[1]) ? ST_WR1 : ST_IDLE;
         ST_WR1:   state_in = pend_nw_en_ff[1] ? ST_WR2 : ST_IDLE;
         ST_WR2:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs: RAM write ports and busy
   always_comb begin
      busy       = (state_ff != ST_IDLE);
      nw_wr_en   = 1'b0;
      nw_wr_addr = idx_ff;
      nw_wr_data = idx_ff;
      ow_wr_en   = 1'b0;
      ow_wr_addr = idx_ff;
      ow_wr_mask = LINK_MASK;
      ow_wr_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ow_wr_en   = 1'b1;
            ow_wr_addr = clr_cnt_ff;
            ow_wr_mask = PRES_MASK;
         end
         ST_LOOK: begin
            nw_wr_en   = plan_nw_en[0];
            nw_wr_addr = plan_nw_addr[0];
            nw_wr_data = plan_nw_data[0];
            ow_wr_en   = plan_ow_en[0];
            ow_wr_addr = plan_ow_addr[0];
            ow_wr_mask = plan_ow_mask[0];
            ow_wr_data = plan_ow_data[0];
         end
         ST_WR1: begin
            nw_wr_en   = pend_nw_en_ff[0];
            nw_wr_addr = pend_nw_addr_ff[0];
            nw_wr_data = pend_nw_data_ff[0];
            ow_wr_en   = pend_ow_en_ff;
            ow_wr_addr = pend_ow_addr_ff;
            ow_wr_mask = pend_ow_mask_ff;
            ow_wr_data = pend_ow_data_ff;
         end
         ST_WR2: begin
            nw_wr_en   = pend_nw_en_ff[1];
            nw_wr_addr = pend_nw_addr_ff[1];
            nw_wr_data = pend_nw_data_ff[1];
         end
         default: ;
      endcase
   end

   // transaction capture, pending writes and result
   always_comb begin
      clr_cnt_in = (state_ff == ST_CLEAR) ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      op_in      = accept ? req_opcode : op_ff;
      idx_in     = accept ? IW'(req_entry) : idx_ff;
      range_in   = accept ? (32'(req_entry) < 32'(ENTRIES)) : range_ff;

      pend_nw_en_in      = pend_nw_en_ff;
      pend_nw_addr_in[0] = pend_nw_addr_ff[0];
      pend_nw_addr_in[1] = pend_nw_addr_ff[1];
      pend_nw_data_in[0] = pend_nw_data_ff[0];
      pend_nw_data_in[1] = pend_nw_data_ff[1];
      pend_ow_en_in      = pend_ow_en_ff;
      pend_ow_addr_in    = pend_ow_addr_ff;
      pend_ow_mask_in    = pend_ow_mask_ff;
      pend_ow_data_in    = pend_ow_data_ff;
      if (state_ff == ST_LOOK) begin
         pend_nw_en_in      = plan_nw_en[2:1];
         pend_nw_addr_in[0] = plan_nw_addr[1];
         pend_nw_addr_in[1] = plan_nw_addr[2];
         pend_nw_data_in[0] = plan_nw_data[1];
         pend_nw_data_in[1] = plan_nw_data[2];
         pend_ow_en_in      = plan_ow_en[1];
         pend_ow_addr_in    = plan_ow_addr[1];
         pend_ow_mask_in    = plan_ow_mask[1];
         pend_ow_data_in    = plan_ow_data[1];
      end

      rsp_valid_in  = (state_ff == ST_LOOK);
      rsp_oldest_in = empty_in ? '0 : ENTRY_W'(oldest_in);
      rsp_newest_in = empty_in ? '0 : ENTRY_W'(newest_in);
      rsp_empty_in  = empty_in;
      rsp_misuse_in = !ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         newest_ff     <= '0;
         oldest_ff     <= '0;
         empty_ff      <= 1'b1;
         pend_nw_en_ff <= '0;
         pend_ow_en_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         newest_ff     <= newest_in;
         oldest_ff     <= oldest_in;
         empty_ff      <= empty_in;
         pend_nw_en_ff <= pend_nw_en_in;
         pend_ow_en_ff <= pend_ow_en_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff              <= op_in;
      idx_ff             <= idx_in;
      range_ff           <= range_in;
      pend_nw_addr_ff[0] <= pend_nw_addr_in[0];
      pend_nw_addr_ff[1] <= pend_nw_addr_in[1];
      pend_nw_data_ff[0] <= pend_nw_data_in[0];
      pend_nw_data_ff[1] <= pend_nw_data_in[1];
      pend_ow_addr_ff    <= pend_ow_addr_in;
      pend_ow_mask_ff    <= pend_ow_mask_in;
      pend_ow_data_ff    <= pend_ow_data_in;
      if (rsp_valid_in) begin
         rsp_oldest_ff <= rsp_oldest_in;
         rsp_newest_ff <= rsp_newest_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_misuse_ff <= rsp_misuse_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_oldest_entry = rsp_oldest_ff;
   assign rsp_newest_entry = rsp_newest_ff;
   assign rsp_list_empty   = rsp_empty_ff;
   assign rsp_misuse       = rsp_misuse_ff;

endmodule

>>> src/lru_recency_list_top.sv
// LRU recency list, top level. The result strobe is registered from the look-up
// state that follows the accepting edge, and is taken at the edge that ends it.
// No new transaction is accepted until the write-back states, set by the writes
// both RAM ports need, are done (a middle touch rewrites three newer links).
// The receiver cannot stall results. Reset: synchronous; afterwards busy stays
// high while the present marks of all ENTRIES slots are swept to zero.
module lru_recency_list_top
   import lrl_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF,
   localparam int IW     = $clog2(ENTRIES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [ENTRY_W-1:0]  req_entry,
   output logic                rsp_valid,
   output logic [ENTRY_W-1:0]  rsp_oldest_entry,
   output logic [ENTRY_W-1:0]  rsp_newest_entry,
   output logic                rsp_list_empty,
   output logic                rsp_misuse
);

   // Newer-link RAM: one link per slot, never cleared; a link is only read
   // for entries that are in the list, whose links were written on entry.
   logic          nw_wr_en;
   logic [IW-1:0] nw_wr_addr, nw_wr_data, nw_rd_addr, nw_rd_data;

   // Second RAM packs the present mark above the older link. The per-bit
   // mask lets a neighbour's link be rewritten without touching its mark,
   // and lets the post-reset sweep clear marks alone.
   logic          ow_wr_en;
   logic [IW-1:0] ow_wr_addr, ow_rd_addr;
   logic [IW:0]   ow_wr_mask, ow_wr_data, ow_rd_data;

   // Both RAMs are read at the accepting edge; the sequencer holds busy
   // until every write-back has landed, so a following read never overlaps
   // a pending write and no forwarding is needed.
   lrl_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_entry        (req_entry),
      .rsp_valid        (rsp_valid),
      .rsp_oldest_entry (rsp_oldest_entry),
      .rsp_newest_entry (rsp_newest_entry),
      .rsp_list_empty   (rsp_list_empty),
      .rsp_misuse       (rsp_misuse),
      .nw_wr_en         (nw_wr_en),
      .nw_wr_addr       (nw_wr_addr),
      .nw_wr_data       (nw_wr_data),
      .nw_rd_addr       (nw_rd_addr),
      .nw_rd_data       (nw_rd_data),
      .ow_wr_en         (ow_wr_en),
      .ow_wr_addr       (ow_wr_addr),
      .ow_wr_mask       (ow_wr_mask),
      .ow_wr_data       (ow_wr_data),
      .ow_rd_addr       (ow_rd_addr),
      .ow_rd_data       (ow_rd_data)
   );

   lrl_ram #(
      .WIDTH (IW),
      .DEPTH (ENTRIES)
   ) u_newer_ram (
      .clock   (clock),
      .wr_en   (nw_wr_en),
      .wr_addr (nw_wr_addr),
      .wr_mask ({IW{1'b1}}),
      .wr_data (nw_wr_data),
      .rd_addr (nw_rd_addr),
      .rd_data (nw_rd_data)
   );

   lrl_ram #(
      .WIDTH (IW + 1),
      .DEPTH (ENTRIES)
   ) u_older_ram (
      .clock   (clock),
      .wr_en   (ow_wr_en),
      .wr_addr (ow_wr_addr),
      .wr_mask (ow_wr_mask),
      .wr_data (ow_wr_data),
      .rd_addr (ow_rd_addr),
      .rd_data (ow_rd_data)
   );

endmodule
